// ----- sv/cht_pkg.sv -----
// Package for the chained hash table engine: operation and status codes,
// state machine type and FNV-1a constants. No dependencies.
package cht_pkg;

   localparam int unsigned KEY_BITS    = 64;
   localparam int unsigned IN_VAL_BITS = 32;
   localparam int unsigned MODE_BITS   = 3;
   localparam int unsigned STATUS_BITS = 3;
   localparam int unsigned COUNT_BITS  = 7;
   localparam int unsigned KLEN_BITS   = 4;

   localparam logic [31:0] FNV_OFFSET = 32'd2166136261;
   localparam logic [31:0] FNV_PRIME  = 32'd16777619;

   localparam logic [MODE_BITS-1:0] MODE_INSERT = 3'd0;
   localparam logic [MODE_BITS-1:0] MODE_ERASE  = 3'd1;
   localparam logic [MODE_BITS-1:0] MODE_LOOKUP = 3'd2;
   localparam logic [MODE_BITS-1:0] MODE_UPDATE = 3'd3;
   localparam logic [MODE_BITS-1:0] MODE_CLEAR  = 3'd4;
   // Codes above clear carry no operation; the item is ignored.
   localparam logic [MODE_BITS-1:0] MODE_IGNORED_FIRST = 3'd5;
   localparam logic [MODE_BITS-1:0] MODE_IGNORED_LAST  = 3'd7;

   localparam logic [STATUS_BITS-1:0] ST_OK      = 3'd0;
   localparam logic [STATUS_BITS-1:0] ST_DUP     = 3'd1;
   localparam logic [STATUS_BITS-1:0] ST_MISSING = 3'd2;
   localparam logic [STATUS_BITS-1:0] ST_NOVAL   = 3'd3;
   localparam logic [STATUS_BITS-1:0] ST_FULL    = 3'd4;

   typedef enum logic [3:0] {
      S_IDLE,
      S_HASH,
      S_HEAD,
      S_READ,
      S_CMP,
      S_ACT,
      S_ALLOC,
      S_CLEAR,
      S_DONE
   } state_type;

   typedef struct packed {
      logic                   start;
      logic [KLEN_BITS-1:0]   nbytes;
   } hash_ctl_type;

endpackage

// ----- sv/cht_if.sv -----
// Valid/ready channel interfaces for the chained hash table engine.
// Depends on cht_pkg for field widths.
interface cht_req_if;
   import cht_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [MODE_BITS-1:0]   mode;
   logic [KEY_BITS-1:0]    key;
   logic [IN_VAL_BITS-1:0] value;
   logic                   value_present;
   modport source (output valid, mode, key, value, value_present, input ready);
   modport sink   (input valid, mode, key, value, value_present, output ready);
endinterface

interface cht_rsp_if;
   import cht_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [STATUS_BITS-1:0] status;
   logic [IN_VAL_BITS-1:0] found_value;
   logic [COUNT_BITS-1:0]  entry_count;
   modport source (output valid, status, found_value, entry_count, input ready);
   modport sink   (input valid, status, found_value, entry_count, output ready);
endinterface

interface cht_csr_if;
   import cht_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [KLEN_BITS-1:0] data;
   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

// ----- sv/chained_hash_table_engine_top.sv -----
// Chained hash table engine: FNV-1a bucket select, chain walk, free-list pool.
// Each item is hashed a key byte at a time and its bucket head read, then chain entries are
// read and compared until a match or the chain end; the engine then acts and finishes, an
// insert that takes a pool slot with an extra allocate step. Clear walks the bucket heads, then
// the link store; an ignored mode goes straight to done. One item at a time: the request side
// is ready again in the cycle after the result transfer. Synchronous reset runs the clearing pass.
module chained_hash_table_engine_top #(
   parameter int unsigned BUCKETS    = 16,
   parameter int unsigned ENTRIES    = 64,
   parameter int unsigned VALUE_BITS = 32
) (
   input  logic      clock,
   input  logic      reset,
   cht_req_if.sink   req,
   cht_rsp_if.source rsp,
   cht_csr_if.sink   csr
);
   import cht_pkg::*;

   localparam int unsigned BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
   localparam int unsigned IW = $clog2(ENTRIES + 1);
   localparam int unsigned EW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int unsigned CW = (BUCKETS + ENTRIES > 1) ? $clog2(BUCKETS + ENTRIES) : 1;
   localparam logic [IW-1:0] NIL = IW'(ENTRIES);

   // Memories. The head and link stores are rebuilt by the clearing pass.
   logic [IW-1:0]         head_mem [BUCKETS];
   logic [IW-1:0]         link_mem [ENTRIES];
   logic [KEY_BITS-1:0]   key_mem  [ENTRIES];
   logic [VALUE_BITS-1:0] val_mem  [ENTRIES];
   logic                  hasv_mem [ENTRIES];

   state_type state_ff, state_in;

   logic [KLEN_BITS-1:0]   klen_ff;
   logic [MODE_BITS-1:0]   mode_ff;
   logic [KEY_BITS-1:0]    key_ff;
   logic [VALUE_BITS-1:0]  val_ff;
   logic                   has_ff;
   logic [BW-1:0]          bucket_ff;
   logic [IW-1:0]          cur_ff, cur_in;
   logic [IW-1:0]          prev_ff, prev_in;
   logic [IW-1:0]          free_ff;
   logic [COUNT_BITS-1:0]  count_ff;
   logic [CW-1:0]          clr_ff;
   logic [STATUS_BITS-1:0] status_ff;
   logic [IN_VAL_BITS-1:0] found_ff;
   logic                   rsp_valid_ff;
   // Marks that a request transfer is in work, so the reset pass stays silent.
   logic                   pending_ff;

   // Registered memory read data.
   logic [IW-1:0]         rd_head_ff, rd_link_ff;
   logic [KEY_BITS-1:0]   rd_key_ff;
   logic [VALUE_BITS-1:0] rd_val_ff;
   logic                  rd_has_ff;

   hash_ctl_type hctl;
   logic         hdone;
   logic [31:0]  hval;
   logic [KLEN_BITS-1:0] neff;
   logic [KEY_BITS-1:0]  kmask;
   logic                 match;

   always_comb begin
      neff = klen_ff;
      if (klen_ff == 4'd0) begin
         neff = 4'd1;
      end else if (klen_ff > 4'd8) begin
         neff = 4'd8;
      end
   end

   assign kmask = (neff == 4'd8) ? '1 : ((KEY_BITS'(1) << {neff[2:0], 3'b000}) - KEY_BITS'(1));
   assign match = ((rd_key_ff ^ key_ff) & kmask) == '0;

   assign req.ready = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign csr.ready = 1'b1;

   logic req_xfer;
   assign req_xfer = req.valid && req.ready;

   assign hctl.start  = req_xfer;
   assign hctl.nbytes = neff;

   // The hash unit reads the captured key, which holds while the item is in work.
   cht_hash u_hash (
      .clock (clock),
      .reset (reset),
      .ctl   (hctl),
      .key   (key_ff),
      .done  (hdone),
      .hash  (hval)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               if (req.mode == MODE_CLEAR) begin
                  state_in = S_CLEAR;
               end else if (req.mode > MODE_CLEAR) begin
                  state_in = S_DONE;
               end else begin
                  state_in = S_HASH;
               end
            end
         end
         S_HASH:  if (hdone) state_in = S_HEAD;
         S_HEAD:  state_in = S_READ;
         S_READ:  state_in = (cur_ff == NIL) ? S_ACT : S_CMP;
         S_CMP:   state_in = match ? S_ACT : S_READ;
         S_ACT:   state_in = (mode_ff == MODE_INSERT && cur_ff == NIL && free_ff != NIL)
                             ? S_ALLOC : S_DONE;
         S_ALLOC: state_in = S_DONE;
         S_CLEAR: if (clr_ff == CW'(BUCKETS + ENTRIES - 1)) state_in = S_DONE;
         S_DONE:  state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // Chain cursor.
   always_comb begin
      cur_in  = cur_ff;
      prev_in = prev_ff;
      case (state_ff)
         S_HEAD: begin
            cur_in  = head_mem[bucket_ff];
            prev_in = NIL;
         end
         S_CMP: begin
            if (!match) begin
               prev_in = cur_ff;
               cur_in  = rd_link_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         klen_ff      <= 4'd8;
         rsp_valid_ff <= 1'b0;
         free_ff      <= '0;
         count_ff     <= '0;
      end else begin
         state_ff <= state_in;
         cur_ff   <= cur_in;
         prev_ff  <= prev_in;
         if (csr.valid) begin
            klen_ff <= csr.data;
         end
         if (rsp.valid && rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_xfer) begin
                  mode_ff   <= req.mode;
                  key_ff    <= req.key;
                  val_ff    <= VALUE_BITS'(req.value);
                  has_ff    <= req.value_present;
                  status_ff <= ST_OK;
                  found_ff  <= '0;
                  clr_ff    <= '0;
               end
            end
            S_HASH: bucket_ff <= hval[BW-1:0];
            S_READ: begin
               if (cur_ff != NIL) begin
                  rd_key_ff  <= key_mem[cur_ff[EW-1:0]];
                  rd_link_ff <= link_mem[cur_ff[EW-1:0]];
                  rd_val_ff  <= val_mem[cur_ff[EW-1:0]];
                  rd_has_ff  <= hasv_mem[cur_ff[EW-1:0]];
               end
            end
            S_ACT: begin
               if (mode_ff == MODE_INSERT) begin
                  if (cur_ff != NIL) begin
                     status_ff <= ST_DUP;
                  end else if (free_ff == NIL) begin
                     status_ff <= ST_FULL;
                  end else begin
                     rd_head_ff <= link_mem[free_ff[EW-1:0]];
                     key_mem[free_ff[EW-1:0]]  <= key_ff;
                     hasv_mem[free_ff[EW-1:0]] <= has_ff;
                     val_mem[free_ff[EW-1:0]]  <= has_ff ? val_ff : '0;
                     link_mem[free_ff[EW-1:0]] <= head_mem[bucket_ff];
                     head_mem[bucket_ff]       <= free_ff;
                     count_ff <= count_ff + COUNT_BITS'(1);
                  end
               end else if (cur_ff == NIL) begin
                  status_ff <= ST_MISSING;
               end else if (mode_ff == MODE_ERASE) begin
                  if (prev_ff != NIL) begin
                     link_mem[prev_ff[EW-1:0]] <= rd_link_ff;
                  end else begin
                     head_mem[bucket_ff] <= rd_link_ff;
                  end
                  link_mem[cur_ff[EW-1:0]] <= free_ff;
                  free_ff <= cur_ff;
                  if (count_ff != '0) count_ff <= count_ff - COUNT_BITS'(1);
               end else if (mode_ff == MODE_LOOKUP) begin
                  if (rd_has_ff) begin
                     found_ff <= IN_VAL_BITS'(rd_val_ff);
                  end else begin
                     status_ff <= ST_NOVAL;
                  end
               end else begin
                  hasv_mem[cur_ff[EW-1:0]] <= has_ff;
                  val_mem[cur_ff[EW-1:0]]  <= has_ff ? val_ff : '0;
               end
            end
            S_ALLOC: free_ff <= rd_head_ff;
            S_CLEAR: begin
               // First the bucket heads, then the link store in pool order.
               if (clr_ff < CW'(BUCKETS)) begin
                  head_mem[clr_ff[BW-1:0]] <= NIL;
               end else begin
                  link_mem[EW'(clr_ff - CW'(BUCKETS))] <= IW'(clr_ff - CW'(BUCKETS)) + IW'(1);
               end
               clr_ff   <= clr_ff + CW'(1);
               free_ff  <= '0;
               count_ff <= '0;
            end
            default: begin
            end
         endcase
         // The reset pass also ends in the done step; only a request raises a result.
         if (state_ff == S_DONE && pending_ff) begin
            rsp_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= 1'b0;
      end else if (req_xfer) begin
         pending_ff <= 1'b1;
      end else if (state_ff == S_DONE) begin
         pending_ff <= 1'b0;
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.status      = status_ff;
   assign rsp.found_value = found_ff;
   assign rsp.entry_count = count_ff;

   // A request is only taken with the result register empty.
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      req.valid && req.ready |-> !rsp.valid) else $error("request over pending result");
   // The stored count never exceeds the pool size.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_BITS'(ENTRIES)) else $error("entry count overflow");
   // A result appears only in the cycle after the done step.
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp.valid) |-> $past(state_ff == S_DONE)) else $error("stray result");
endmodule

// ----- sv/cht_hash.sv -----
// Serial FNV-1a hash unit: one key byte per cycle through one 32x32 multiply.
// Depends on cht_pkg.
module cht_hash (
   input  logic                           clock,
   input  logic                           reset,
   input  cht_pkg::hash_ctl_type          ctl,
   input  logic [cht_pkg::KEY_BITS-1:0]   key,
   output logic                           done,
   output logic [31:0]                    hash
);
   import cht_pkg::*;

   logic [31:0] h_ff, h_in;
   logic [3:0]  idx_ff, idx_in;
   logic [3:0]  n_ff, n_in;
   logic        busy_ff, busy_in;
   logic [7:0]  kbyte;
   logic [63:0] shifted;

   assign shifted = key >> {idx_ff[2:0], 3'b000};
   assign kbyte   = shifted[7:0];

   always_comb begin
      h_in    = h_ff;
      idx_in  = idx_ff;
      n_in    = n_ff;
      busy_in = busy_ff;
      if (ctl.start) begin
         h_in    = FNV_OFFSET;
         idx_in  = 4'd0;
         n_in    = ctl.nbytes;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         h_in   = (h_ff ^ {24'd0, kbyte}) * FNV_PRIME;
         idx_in = idx_ff + 4'd1;
         if (idx_ff + 4'd1 == n_ff) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      h_ff   <= h_in;
      idx_ff <= idx_in;
      n_ff   <= n_in;
   end

   assign done = !busy_ff && !ctl.start;
   assign hash = h_ff;
endmodule
